/* hdl/dda_pkg.sv */
// ----------------------------------------------------------------------------
// dda_pkg
// Shared widths, payload helpers and control types of the DDA line rasteriser.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_W      = 6;
    localparam int COLOR_W      = 32;
    localparam int TILE_SIZE_DEF = 64;

    // Control from the sequencer to each axis accumulator
    typedef struct packed {
        logic load;
        logic step;
    } axis_ctrl_t;

    // Clamp a coordinate at or above the tile size to the last tile column
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic [COORD_W-1:0] v,
        input logic [COORD_W:0]   tile
    );
        logic [COORD_W:0] lim;
        lim = tile - 1'b1;
        if ({1'b0, v} >= tile)
            return lim[COORD_W-1:0];
        return v;
    endfunction

endpackage

/* hdl/dda_line_if.sv */
// ----------------------------------------------------------------------------
// dda_line_if
// Line command channel: start point, end point and colour.
// ----------------------------------------------------------------------------
interface dda_line_if;
    import dda_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] line_color;

    modport source (output valid, output x_start, output y_start, output x_end,
                    output y_end, output line_color, input ready);
    modport sink   (input valid, input x_start, input y_start, input x_end,
                    input y_end, input line_color, output ready);
endinterface

/* hdl/dda_pixel_if.sv */
// ----------------------------------------------------------------------------
// dda_pixel_if
// Pixel channel: coordinates, colour and end-of-line flag.
// ----------------------------------------------------------------------------
interface dda_pixel_if;
    import dda_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                    input last_pixel, output ready);
endinterface

/* hdl/dda_axis.sv */
// ----------------------------------------------------------------------------
// dda_axis
// Remainder accumulator for one axis: exact floor(start + i*delta/L + 1/2).
// ----------------------------------------------------------------------------
module dda_axis (
    input  logic                                 clk,
    input  dda_pkg::axis_ctrl_t                  ctrl,
    input  logic        [dda_pkg::COORD_W-1:0]   start,
    input  logic signed [dda_pkg::COORD_W:0]     delta,
    input  logic        [dda_pkg::COORD_W-1:0]   len,
    output logic        [dda_pkg::COORD_W-1:0]   pos
);
    import dda_pkg::*;

    localparam int D_W = COORD_W + 2;   // twice the delta, signed
    localparam int R_W = COORD_W + 3;   // remainder plus one step

    logic        [COORD_W-1:0] pos_reg,   pos_next;
    logic signed [R_W-1:0]     rem_reg,   rem_next;
    logic signed [D_W-1:0]     twod_reg;
    logic signed [D_W-1:0]     twol_reg;
    logic signed [R_W-1:0]     rem_sum;

    assign rem_sum = rem_reg + R_W'(twod_reg);

    always_comb
    begin
        pos_next = pos_reg;
        rem_next = rem_reg;
        if (ctrl.load)
        begin
            pos_next = start;
            rem_next = $signed(R_W'(len));
        end
        else if (ctrl.step)
        begin
            // one correction keeps the remainder in [0, 2L)
            if (rem_sum >= R_W'(twol_reg))
            begin
                rem_next = rem_sum - R_W'(twol_reg);
                pos_next = pos_reg + 1'b1;
            end
            else if (rem_sum < 0)
            begin
                rem_next = rem_sum + R_W'(twol_reg);
                pos_next = pos_reg - 1'b1;
            end
            else
            begin
                rem_next = rem_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        rem_reg <= rem_next;
        if (ctrl.load)
        begin
            twod_reg <= {delta, 1'b0};
            twol_reg <= $signed({1'b0, len, 1'b0});
        end
    end

    assign pos = pos_reg;

endmodule

/* hdl/dda_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// Output: a command transfer moves the sequencer to ST_RUN and loads the axis
// accumulators; the output register then takes the first pixel; L+1 pixels a line.
// Throughput: one pixel a cycle unless the pixel sink stalls; commands only in ST_IDLE.
// Reset: rst_n asynchronous, clears sequencer and output valid, not the payload.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
    parameter int TILE_SIZE = dda_pkg::TILE_SIZE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    dda_line_if.sink     cmd,
    dda_pixel_if.source  pix
);
    import dda_pkg::*;

    localparam logic [COORD_W:0] TILE = (COORD_W+1)'(TILE_SIZE);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [COORD_W-1:0]  remain_reg, remain_next;
    logic [COLOR_W-1:0]  color_reg;
    logic                out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]  out_x_reg, out_y_reg;
    logic [COLOR_W-1:0]  out_color_reg;
    logic                out_last_reg;

    logic [COORD_W-1:0]        x0, y0, x1, y1;
    logic signed [COORD_W:0]   dx, dy;
    logic signed [COORD_W:0]   ndx, ndy;
    logic [COORD_W-1:0]        ax, ay, len;
    logic                      cmd_xfer, emit, last;
    axis_ctrl_t                actl;
    logic [COORD_W-1:0]        pos_x, pos_y;

    assign x0 = clamp_coord(cmd.x_start, TILE);
    assign y0 = clamp_coord(cmd.y_start, TILE);
    assign x1 = clamp_coord(cmd.x_end, TILE);
    assign y1 = clamp_coord(cmd.y_end, TILE);

    assign dx  = $signed({1'b0, x1}) - $signed({1'b0, x0});
    assign dy  = $signed({1'b0, y1}) - $signed({1'b0, y0});
    assign ndx = -dx;
    assign ndy = -dy;
    assign ax  = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
    assign ay  = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
    assign len = (ax >= ay) ? ax : ay;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;

    // load the output register when it is empty or its pixel leaves now
    assign emit = (state_reg == ST_RUN) && (!out_valid_reg || pix.ready);
    assign last = (remain_reg == '0);

    assign actl.load = cmd_xfer;
    assign actl.step = emit && !last;

    dda_axis u_axis_x (
        .clk   (clk),
        .ctrl  (actl),
        .start (x0),
        .delta (dx),
        .len   (len),
        .pos   (pos_x)
    );

    dda_axis u_axis_y (
        .clk   (clk),
        .ctrl  (actl),
        .start (y0),
        .delta (dy),
        .len   (len),
        .pos   (pos_y)
    );

    always_comb
    begin
        state_next     = state_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && pix.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    remain_next = len;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    if (last)
                        state_next = ST_IDLE;
                    else
                        remain_next = remain_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
            color_reg <= cmd.line_color;
        if (emit)
        begin
            out_x_reg     <= pos_x;
            out_y_reg     <= pos_y;
            out_color_reg <= color_reg;
            out_last_reg  <= last;
        end
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = out_x_reg;
    assign pix.pixel_y     = out_y_reg;
    assign pix.pixel_color = out_color_reg;
    assign pix.last_pixel  = out_last_reg;

endmodule
